// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, quiet while rst_n is low.
`define WGCS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wave grid check failed");

// Same check with a fixed message for handshake rules.
`define WGCS_ASSERT_HS(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("wave grid handshake rule broken");

`endif

// ----- sv/wgcs_pkg.sv -----
package wgcs_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int X_BITS     = $clog2(MAX_WIDTH);
    localparam int Y_BITS     = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS  = X_BITS + Y_BITS;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int SIZE_BITS  = 7;

    typedef logic [12:0]        color_t;
    typedef logic signed [14:0] vel_t;
    typedef logic [2:0][12:0]   rgb_t;
    typedef logic [2:0][14:0]   rgbv_t;

    typedef struct packed {
        color_t c;
        vel_t   v;
    } settle_t;

    localparam color_t ONE_COLOR = 13'd4096;
    localparam vel_t   VEL_LIMIT = 15'sd8192;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_STAMP = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    function automatic logic [SIZE_BITS-1:0] used_size(logic [SIZE_BITS-1:0] v,
                                                       logic [SIZE_BITS-1:0] maxv);
        logic [SIZE_BITS-1:0] r;
        r = v;
        if (v < SIZE_BITS'(2))
        begin
            r = SIZE_BITS'(2);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic settle_t settle(color_t c, vel_t v);
        logic signed [16:0] s;
        settle_t r;
        s = $signed({4'b0, c}) + $signed({{2{v[14]}}, v});
        r.c = s[12:0];
        r.v = v;
        if (s > 17'sd4096)
        begin
            r.c = ONE_COLOR;
            r.v = '0;
        end
        else if (s < 17'sd0)
        begin
            r.c = '0;
            r.v = '0;
        end
        return r;
    endfunction

    function automatic color_t sat_color(logic [12:0] v);
        return (v > ONE_COLOR) ? ONE_COLOR : v;
    endfunction

endpackage

// ----- sv/wave_grid_color_step.sv -----
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | action, cell_x, cell_y, stamp_red/green/blue
// out     | out_valid| out_stall | read_red, read_green, read_blue, status
// cfg     | cfg_wr_en| -         | cfg_index, cfg_data
// Tick: each cell takes five colour reads on the single read port and one pass
// of the shared divide/gain/velocity unit per component; parallel mode then
// settles every cell in a second pass. Clear writes all 4096 cells, one cell a
// cycle; stamp visits the 3x3 block; read takes ST_READ and ST_RCAP; every word
// ends in ST_FIN to hand over. After reset a clearing pass over all cells runs with in_stall high.
// in_stall is high while a word is in work; a finished word waits in the output
// register under out_stall, and the next word is taken meanwhile.
module wave_grid_color_step
    import wgcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [12:0] stamp_red,
    input  logic [12:0] stamp_green,
    input  logic [12:0] stamp_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] read_red,
    output logic [12:0] read_green,
    output logic [12:0] read_blue,
    output logic        status,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_TRD   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_GAIN  = 4'd4;
    localparam logic [3:0] ST_VEL   = 4'd5;
    localparam logic [3:0] ST_TWR   = 4'd6;
    localparam logic [3:0] ST_SRD   = 4'd7;
    localparam logic [3:0] ST_SWR   = 4'd8;
    localparam logic [3:0] ST_STAMP = 4'd9;
    localparam logic [3:0] ST_READ  = 4'd10;
    localparam logic [3:0] ST_RCAP  = 4'd11;
    localparam logic [3:0] ST_FIN   = 4'd12;

    logic [3:0]           state_reg;
    logic                 boot_reg;
    logic                 mode_reg;
    logic [8:0]           gain_reg;
    logic [SIZE_BITS-1:0] width_reg;
    logic [SIZE_BITS-1:0] height_reg;

    logic [X_BITS-1:0]    cx_reg;
    logic [Y_BITS-1:0]    cy_reg;
    rgb_t                 stamp_reg;
    rgb_t                 res_rgb_reg;
    logic                 res_status_reg;

    logic [X_BITS-1:0]    x_reg;
    logic [Y_BITS-1:0]    y_reg;
    logic [2:0]           step_reg;
    logic [1:0]           comp_reg;
    logic [ADDR_BITS-1:0] clr_reg;
    logic [1:0]           dx_reg;
    logic [1:0]           dy_reg;

    rgb_t                 self_reg;
    rgbv_t                vel_reg;
    logic signed [15:0]   sum_reg [3];
    logic [13:0]          q_reg;
    logic                 neg_reg;
    logic [14:0]          p_reg;
    rgbv_t                vnew_reg;

    logic                 out_valid_reg;
    rgb_t                 out_rgb_reg;
    logic                 out_status_reg;

    logic [38:0]          color_mem [CELLS];
    logic [44:0]          vel_mem [CELLS];
    rgb_t                 color_q;
    rgbv_t                vel_q;

    logic                 color_we;
    logic                 vel_we;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] color_ra;
    logic [ADDR_BITS-1:0] cell_addr;
    rgb_t                 color_wd;
    rgbv_t                vel_wd;

    logic [SIZE_BITS-1:0] w_use;
    logic [SIZE_BITS-1:0] h_use;
    logic                 has_w;
    logic                 has_e;
    logic                 has_n;
    logic                 has_s;
    logic [3:0]           nb_mask;
    logic [2:0]           nb_count;
    logic [15:0]          recip;
    logic                 last_cell;
    logic                 in_accept;
    logic                 coord_bad;

    logic signed [15:0]   sum_sel;
    logic [15:0]          sum_mag;
    logic [30:0]          div_prod;
    logic [22:0]          gain_prod;
    logic signed [16:0]   vel_sum;
    vel_t                 vel_cur;

    logic [SIZE_BITS-1:0] px;
    logic [SIZE_BITS-1:0] py;
    logic                 stamp_ok;
    logic                 stamp_last;

    assign w_use     = used_size(width_reg, SIZE_BITS'(MAX_WIDTH));
    assign h_use     = used_size(height_reg, SIZE_BITS'(MAX_HEIGHT));
    assign cell_addr = {x_reg, y_reg};
    assign has_w     = (x_reg != '0);
    assign has_e     = (({1'b0, x_reg} + SIZE_BITS'(1)) < w_use);
    assign has_n     = (y_reg != '0);
    assign has_s     = (({1'b0, y_reg} + SIZE_BITS'(1)) < h_use);
    assign nb_mask   = {has_s, has_n, has_e, has_w};
    assign nb_count  = 3'(has_w) + 3'(has_e) + 3'(has_n) + 3'(has_s);
    assign last_cell = (({1'b0, x_reg} + SIZE_BITS'(1)) == w_use)
                    && (({1'b0, y_reg} + SIZE_BITS'(1)) == h_use);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign coord_bad = ({1'b0, cell_x} >= w_use) || ({1'b0, cell_y} >= h_use);

    always_comb
    begin
        case (nb_count)
            3'd3:    recip = 16'd21846;
            3'd4:    recip = 16'd16384;
            default: recip = 16'd32768;
        endcase
    end

    assign sum_sel   = sum_reg[comp_reg];
    assign sum_mag   = sum_sel[15] ? 16'(-sum_sel) : 16'(sum_sel);
    assign div_prod  = 31'(sum_mag[14:0]) * 31'(recip);
    assign gain_prod = 23'(q_reg) * 23'(gain_reg);
    assign vel_cur   = vel_reg[comp_reg];
    assign vel_sum   = $signed({{2{vel_cur[14]}}, vel_cur})
                     + (neg_reg ? -$signed({2'b0, p_reg}) : $signed({2'b0, p_reg}));

    assign px = {1'b0, cx_reg} + SIZE_BITS'(dx_reg) - SIZE_BITS'(1);
    assign py = {1'b0, cy_reg} + SIZE_BITS'(dy_reg) - SIZE_BITS'(1);
    assign stamp_ok = !(cx_reg == '0 && dx_reg == 2'd0) && (px < w_use)
                   && !(cy_reg == '0 && dy_reg == 2'd0) && (py < h_use);
    assign stamp_last = (dx_reg == 2'd2) && (dy_reg == 2'd2);

    always_comb
    begin
        case (state_reg)
            ST_TRD:
            begin
                case (step_reg)
                    3'd1:    color_ra = {x_reg - X_BITS'(1), y_reg};
                    3'd2:    color_ra = {x_reg + X_BITS'(1), y_reg};
                    3'd3:    color_ra = {x_reg, y_reg - Y_BITS'(1)};
                    3'd4:    color_ra = {x_reg, y_reg + Y_BITS'(1)};
                    default: color_ra = cell_addr;
                endcase
            end
            ST_READ: color_ra = {cx_reg, cy_reg};
            default: color_ra = cell_addr;
        endcase
    end

    always_comb
    begin
        settle_t st;
        color_we = 1'b0;
        vel_we   = 1'b0;
        wr_addr  = cell_addr;
        color_wd = self_reg;
        vel_wd   = vnew_reg;
        st       = '0;
        case (state_reg)
            ST_CLR:
            begin
                color_we = 1'b1;
                vel_we   = 1'b1;
                wr_addr  = clr_reg;
                color_wd = {3{ONE_COLOR}};
                vel_wd   = '0;
            end
            ST_TWR:
            begin
                vel_we = 1'b1;
                if (mode_reg)
                begin
                    color_we = 1'b1;
                    for (int c = 0; c < 3; c++)
                    begin
                        st = settle(self_reg[c], vnew_reg[c]);
                        color_wd[c] = st.c;
                        vel_wd[c]   = st.v;
                    end
                end
            end
            ST_SWR:
            begin
                color_we = 1'b1;
                vel_we   = 1'b1;
                for (int c = 0; c < 3; c++)
                begin
                    st = settle(color_q[c], vel_q[c]);
                    color_wd[c] = st.c;
                    vel_wd[c]   = st.v;
                end
            end
            ST_STAMP:
            begin
                color_we = stamp_ok;
                vel_we   = stamp_ok;
                wr_addr  = {px[X_BITS-1:0], py[Y_BITS-1:0]};
                color_wd = stamp_reg;
                vel_wd   = '0;
            end
            default:
            begin
                color_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[wr_addr] <= color_wd;
        end
        color_q <= color_mem[color_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
        begin
            vel_mem[wr_addr] <= vel_wd;
        end
        vel_q <= vel_mem[cell_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            gain_reg   <= 9'd102;
            width_reg  <= SIZE_BITS'(64);
            height_reg <= SIZE_BITS'(64);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_GAIN:   gain_reg   <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_BITS-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_BITS-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            boot_reg      <= 1'b1;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR:
                begin
                    clr_reg <= clr_reg + ADDR_BITS'(1);
                    if (clr_reg == {ADDR_BITS{1'b1}})
                    begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_FIN;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        cx_reg         <= cell_x;
                        cy_reg         <= cell_y;
                        stamp_reg      <= {sat_color(stamp_blue), sat_color(stamp_green),
                                           sat_color(stamp_red)};
                        res_rgb_reg    <= '0;
                        res_status_reg <= 1'b0;
                        x_reg          <= '0;
                        y_reg          <= '0;
                        step_reg       <= '0;
                        dx_reg         <= '0;
                        dy_reg         <= '0;
                        clr_reg        <= '0;
                        case (action)
                            ACT_TICK:  state_reg <= ST_TRD;
                            ACT_CLEAR: state_reg <= ST_CLR;
                            ACT_STAMP:
                            begin
                                res_status_reg <= coord_bad;
                                state_reg      <= coord_bad ? ST_FIN : ST_STAMP;
                            end
                            default:
                            begin
                                res_status_reg <= coord_bad;
                                state_reg      <= coord_bad ? ST_FIN : ST_READ;
                            end
                        endcase
                    end
                end
                ST_TRD:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd1)
                    begin
                        self_reg <= color_q;
                        vel_reg  <= vel_q;
                        for (int c = 0; c < 3; c++)
                        begin
                            sum_reg[c] <= '0;
                        end
                    end
                    if (step_reg >= 3'd2)
                    begin
                        if (nb_mask[2'(step_reg - 3'd2)])
                        begin
                            for (int c = 0; c < 3; c++)
                            begin
                                sum_reg[c] <= sum_reg[c]
                                    + 16'($signed({1'b0, color_q[c]})
                                    - $signed({1'b0, self_reg[c]}));
                            end
                        end
                    end
                    if (step_reg == 3'd5)
                    begin
                        comp_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    q_reg     <= div_prod[29:16];
                    neg_reg   <= sum_sel[15];
                    state_reg <= ST_GAIN;
                end
                ST_GAIN:
                begin
                    p_reg     <= gain_prod[22:8];
                    state_reg <= ST_VEL;
                end
                ST_VEL:
                begin
                    if (vel_sum > 17'sd8192)
                    begin
                        vnew_reg[comp_reg] <= VEL_LIMIT;
                    end
                    else if (vel_sum < -17'sd8192)
                    begin
                        vnew_reg[comp_reg] <= -VEL_LIMIT;
                    end
                    else
                    begin
                        vnew_reg[comp_reg] <= vel_sum[14:0];
                    end
                    comp_reg  <= comp_reg + 2'd1;
                    state_reg <= (comp_reg == 2'd2) ? ST_TWR : ST_DIV;
                end
                ST_TWR:
                begin
                    step_reg <= '0;
                    if (last_cell)
                    begin
                        x_reg     <= '0;
                        y_reg     <= '0;
                        state_reg <= mode_reg ? ST_FIN : ST_SRD;
                    end
                    else
                    begin
                        if (({1'b0, y_reg} + SIZE_BITS'(1)) == h_use)
                        begin
                            y_reg <= '0;
                            x_reg <= x_reg + X_BITS'(1);
                        end
                        else
                        begin
                            y_reg <= y_reg + Y_BITS'(1);
                        end
                        state_reg <= ST_TRD;
                    end
                end
                ST_SRD:
                begin
                    state_reg <= ST_SWR;
                end
                ST_SWR:
                begin
                    if (({1'b0, y_reg} + SIZE_BITS'(1)) == h_use)
                    begin
                        y_reg <= '0;
                        x_reg <= x_reg + X_BITS'(1);
                    end
                    else
                    begin
                        y_reg <= y_reg + Y_BITS'(1);
                    end
                    state_reg <= last_cell ? ST_FIN : ST_SRD;
                end
                ST_STAMP:
                begin
                    if (dy_reg == 2'd2)
                    begin
                        dy_reg <= '0;
                        dx_reg <= dx_reg + 2'd1;
                    end
                    else
                    begin
                        dy_reg <= dy_reg + 2'd1;
                    end
                    if (stamp_last)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_RCAP;
                end
                ST_RCAP:
                begin
                    res_rgb_reg <= color_q;
                    state_reg   <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_rgb_reg    <= res_rgb_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_red   = out_rgb_reg[0];
    assign read_green = out_rgb_reg[1];
    assign read_blue  = out_rgb_reg[2];
    assign status     = out_status_reg;

endmodule

// ----- sv/wgcs_checker.sv -----
`include "assert_macros.svh"

module wgcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [12:0] read_red,
    input logic [12:0] read_green,
    input logic [12:0] read_blue,
    input logic        status
);

    `WGCS_ASSERT_HS(a_out_hold, out_valid && out_stall |=> out_valid)
    `WGCS_ASSERT_HS(a_out_stable, out_valid && out_stall |=> $stable(read_red) && $stable(status))
    `WGCS_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall)
    `WGCS_ASSERT(a_flag_no_color, out_valid && status |-> (read_red | read_green | read_blue) == 13'd0)

endmodule

bind wave_grid_color_step wgcs_checker u_wgcs_checker (.*);

// ----- tb/wave_grid_checker.sv -----
module wave_grid_checker
    import wgcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [12:0] stamp_red,
    input  logic [12:0] stamp_green,
    input  logic [12:0] stamp_blue,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [12:0] read_red,
    input  logic [12:0] read_green,
    input  logic [12:0] read_blue,
    input  logic        status,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [12:0] red;
        logic [12:0] green;
        logic [12:0] blue;
        logic        flag;
    } readout_t;

    readout_t   readout_q[$];
    int         hue[0:CELLS-1][0:2];
    int         speed[0:CELLS-1][0:2];
    logic       mode_seq;
    int         gain_val;
    int         width_reg;
    int         height_reg;

    function automatic int size_in_use(int v, int maxv);
        if (v < 2)
        begin
            return 2;
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return v;
    endfunction

    function automatic void whiten_grid();
        for (int i = 0; i < CELLS; i++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                hue[i][c] = 4096;
                speed[i][c] = 0;
            end
        end
    endfunction

    function automatic void settle_cell(int i);
        int v;
        for (int c = 0; c < 3; c++)
        begin
            v = hue[i][c] + speed[i][c];
            if (v > 4096)
            begin
                v = 4096;
                speed[i][c] = 0;
            end
            else if (v < 0)
            begin
                v = 0;
                speed[i][c] = 0;
            end
            hue[i][c] = v;
        end
    endfunction

    function automatic void push_speed(int x, int y, int w, int h);
        int i;
        int self;
        int sum;
        int n;
        int d;
        int dl;
        int v;
        i = x * MAX_HEIGHT + y;
        for (int c = 0; c < 3; c++)
        begin
            self = hue[i][c];
            sum = 0;
            n = 0;
            if (x > 0)
            begin
                sum += hue[i - MAX_HEIGHT][c] - self;
                n++;
            end
            if (x + 1 < w)
            begin
                sum += hue[i + MAX_HEIGHT][c] - self;
                n++;
            end
            if (y > 0)
            begin
                sum += hue[i - 1][c] - self;
                n++;
            end
            if (y + 1 < h)
            begin
                sum += hue[i + 1][c] - self;
                n++;
            end
            if (n == 0)
            begin
                n = 1;
            end
            d = sum / n;
            dl = (d * gain_val) / 256;
            v = speed[i][c] + dl;
            if (v > 8192)
            begin
                v = 8192;
            end
            if (v < -8192)
            begin
                v = -8192;
            end
            speed[i][c] = v;
        end
    endfunction

    function automatic void wave_tick();
        int w;
        int h;
        w = size_in_use(width_reg, MAX_WIDTH);
        h = size_in_use(height_reg, MAX_HEIGHT);
        for (int x = 0; x < w; x++)
        begin
            for (int y = 0; y < h; y++)
            begin
                push_speed(x, y, w, h);
                if (mode_seq)
                begin
                    settle_cell(x * MAX_HEIGHT + y);
                end
            end
        end
        if (!mode_seq)
        begin
            for (int x = 0; x < w; x++)
            begin
                for (int y = 0; y < h; y++)
                begin
                    settle_cell(x * MAX_HEIGHT + y);
                end
            end
        end
    endfunction

    function automatic readout_t apply_word(logic [1:0] act, int cx, int cy, int sr,
                                            int sg, int sb);
        readout_t r;
        int w;
        int h;
        int rgb[3];
        int i;
        w = size_in_use(width_reg, MAX_WIDTH);
        h = size_in_use(height_reg, MAX_HEIGHT);
        r = '{default: '0};
        if (act == ACT_TICK)
        begin
            wave_tick();
        end
        else if (act == ACT_CLEAR)
        begin
            whiten_grid();
        end
        else if (cx >= w || cy >= h)
        begin
            r.flag = 1'b1;
        end
        else if (act == ACT_STAMP)
        begin
            rgb[0] = sr > 4096 ? 4096 : sr;
            rgb[1] = sg > 4096 ? 4096 : sg;
            rgb[2] = sb > 4096 ? 4096 : sb;
            for (int x = (cx > 0 ? cx - 1 : 0); x <= (cx + 1 < w ? cx + 1 : cx); x++)
            begin
                for (int y = (cy > 0 ? cy - 1 : 0); y <= (cy + 1 < h ? cy + 1 : cy); y++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        hue[x * MAX_HEIGHT + y][c] = rgb[c];
                        speed[x * MAX_HEIGHT + y][c] = 0;
                    end
                end
            end
        end
        else
        begin
            i = cx * MAX_HEIGHT + cy;
            r.red = 13'(hue[i][0]);
            r.green = 13'(hue[i][1]);
            r.blue = 13'(hue[i][2]);
        end
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        readout_t exp_r;
        if (!rst_n)
        begin
            readout_q.delete();
            whiten_grid();
            mode_seq = 1'b0;
            gain_val = 102;
            width_reg = 64;
            height_reg = 64;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_seq = cfg_data[0];
                    CFG_GAIN:   gain_val = int'(cfg_data);
                    CFG_WIDTH:  width_reg = int'(cfg_data[6:0]);
                    CFG_HEIGHT: height_reg = int'(cfg_data[6:0]);
                    default:    ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                readout_q.push_back(apply_word(action, int'(cell_x), int'(cell_y),
                                               int'(stamp_red), int'(stamp_green),
                                               int'(stamp_blue)));
            end
            if (out_valid && !out_stall)
            begin
                if (readout_q.size() == 0)
                begin
                    report("unexpected word", 1, 0);
                end
                else
                begin
                    exp_r = readout_q.pop_front();
                    if (read_red !== exp_r.red)
                        report("read_red", int'(read_red), int'(exp_r.red));
                    if (read_green !== exp_r.green)
                        report("read_green", int'(read_green), int'(exp_r.green));
                    if (read_blue !== exp_r.blue)
                        report("read_blue", int'(read_blue), int'(exp_r.blue));
                    if (status !== exp_r.flag)
                        report("status", int'(status), int'(exp_r.flag));
                end
            end
            pending = readout_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import wgcs_pkg::*;

    localparam int LIMIT = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic [5:0]  cell_x = '0;
    logic [5:0]  cell_y = '0;
    logic [12:0] stamp_red = '0;
    logic [12:0] stamp_green = '0;
    logic [12:0] stamp_blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [12:0] read_red;
    logic [12:0] read_green;
    logic [12:0] read_blue;
    logic        status;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;
    int          fail_count;
    int          pending;
    int          tx_pct = 0;
    int          rx_pct = 0;
    int          cycles = 0;
    int          grid_w = 64;
    int          grid_h = 64;

    wave_grid_color_step u_dut (.*);

    wave_grid_checker u_chk (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < rx_pct);
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int clamp_size(int v);
        return v < 2 ? 2 : (v > 64 ? 64 : v);
    endfunction

    task automatic send_word(logic [1:0] act, int x, int y, int r, int g, int b);
        if ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        cell_x <= 6'(x);
        cell_y <= 6'(y);
        stamp_red <= 13'(r);
        stamp_green <= 13'(g);
        stamp_blue <= 13'(b);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_WIDTH)
            grid_w = clamp_size(data & 7'h7f);
        if (idx == CFG_HEIGHT)
            grid_h = clamp_size(data & 7'h7f);
    endtask

    task automatic rand_word();
        int pick;
        int x;
        int y;
        pick = $urandom_range(99);
        x = ($urandom_range(99) < 85) ? $urandom_range(grid_w - 1) : $urandom_range(63);
        y = ($urandom_range(99) < 85) ? $urandom_range(grid_h - 1) : $urandom_range(63);
        send_word(pick < 20 ? ACT_TICK : pick < 50 ? ACT_STAMP : pick < 96 ? ACT_READ
                  : ACT_CLEAR, x, y,
                  ($urandom_range(99) < 80) ? $urandom_range(4096) : $urandom_range(8191),
                  ($urandom_range(99) < 80) ? $urandom_range(4096) : $urandom_range(8191),
                  ($urandom_range(99) < 80) ? $urandom_range(4096) : $urandom_range(8191));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_word(ACT_READ, 0, 0, 0, 0, 0);
        send_word(ACT_READ, 63, 63, 0, 0, 0);
        send_word(ACT_STAMP, 0, 0, 4096, 0, 8191);
        send_word(ACT_STAMP, 63, 63, 0, 8191, 4097);
        send_word(ACT_STAMP, 30, 20, 1000, 2000, 3000);
        send_word(ACT_TICK, 0, 0, 0, 0, 0);
        send_word(ACT_READ, 1, 1, 0, 0, 0);
        send_word(ACT_READ, 29, 19, 0, 0, 0);

        wait_idle();
        cfg_write(CFG_MODE, 9'h1ff);
        cfg_write(CFG_GAIN, 511);
        cfg_write(CFG_WIDTH, 5);
        cfg_write(CFG_HEIGHT, 3);
        send_word(ACT_STAMP, 4, 2, 0, 0, 0);
        send_word(ACT_STAMP, 5, 0, 0, 0, 0);
        send_word(ACT_READ, 0, 3, 0, 0, 0);
        send_word(ACT_TICK, 0, 0, 0, 0, 0);
        send_word(ACT_TICK, 0, 0, 0, 0, 0);
        send_word(ACT_READ, 2, 1, 0, 0, 0);
        send_word(ACT_READ, 4, 2, 0, 0, 0);

        wait_idle();
        cfg_write(CFG_MODE, 0);
        cfg_write(CFG_GAIN, 0);
        cfg_write(CFG_WIDTH, 1);
        cfg_write(CFG_HEIGHT, 127);
        send_word(ACT_STAMP, 1, 40, 0, 4096, 0);
        send_word(ACT_TICK, 0, 0, 0, 0, 0);
        send_word(ACT_READ, 0, 40, 0, 0, 0);
        send_word(ACT_CLEAR, 63, 63, 0, 0, 0);
        send_word(ACT_READ, 1, 40, 0, 0, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            wait_idle();
            tx_pct = (ph == 0) ? 24 : (ph == 1) ? 46 : 0;
            rx_pct = (ph == 0) ? 46 : (ph == 1) ? 24 : 0;
            cfg_write(CFG_MODE, $urandom_range(1));
            cfg_write(CFG_GAIN, ($urandom_range(3) == 0) ? $urandom_range(511)
                                                          : $urandom_range(256));
            cfg_write(CFG_WIDTH, (ph == 1) ? 64 : $urandom_range(10, 2));
            cfg_write(CFG_HEIGHT, (ph == 2) ? $urandom_range(127, 64)
                                            : $urandom_range(10, 0));
            for (int n = 0; n < 34; n++)
                rand_word();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/wgcs_pkg.sv
sv/wave_grid_color_step.sv
sv/wgcs_checker.sv
tb/wave_grid_checker.sv
tb/tb_top.sv
